>>> sv/md5_message_digest_defines.svh
// Assertion macros for the MD5 digest block.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("md5 assertion failed");
`define MD5_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5 assertion failed");
`else
`define MD5_ASSERT(lbl, clk, rst, prop)
`define MD5_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> sv/md5_pkg.sv
// Shared types, constants and round tables for the MD5 digest block.
`default_nettype none
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [5:0] LAST_POS = 6'h3F;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [6:0] ROUNDS   = 7'd64;

  // one classified transaction between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_end;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_OUT
  } ret_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROUND_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word index used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] rl;
    rl = r[3:0];
    case (r[5:4])
      2'd0:    msg_index = rl;
      2'd1:    msg_index = 4'(4'd1 + 4'(rl * 4'd5));
      2'd2:    msg_index = 4'(4'd5 + 4'(rl * 4'd3));
      default: msg_index = 4'(rl * 4'd7);
    endcase
  endfunction

endpackage
`default_nettype wire

>>> sv/md5_front.sv
// Front part: accepts input transactions, drops empty ones, queues the rest.
`default_nettype none
module md5_front import md5_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       byte_valid,
  input  wire logic       end_of_message,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_ready
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  // items carrying neither byte nor end are accepted and discarded
  assign do_wr = push && !full && (byte_valid || end_of_message);
  assign do_rd = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= '{data: data_byte, has_byte: byte_valid, is_end: end_of_message};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= 2'(count + {1'b0, do_wr} - {1'b0, do_rd});
    end
  end

endmodule
`default_nettype wire

>>> sv/md5_back.sv
// Back part: block packing, padding, 64-round compression and digest output.
`default_nettype none
module md5_back import md5_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_ready,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [1:0]       word_index,
  output logic             last_word
);

  state_t      state, state_next;
  ret_t        ret, ret_next;
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [6:0]  cnt, cnt_next;
  logic [63:0] bit_count, bit_count_next;
  logic [63:0] length, length_next;
  logic        pad_first, pad_first_next;
  logic        len_phase, len_phase_next;
  logic [1:0]  out_idx, out_idx_next;
  logic        out_valid, out_valid_next;

  logic [31:0] mem [16];
  logic [31:0] rdata;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [5:0]  pos;
  logic        load_abcd;
  logic        do_round;
  logic        do_fin;
  logic        load_out;
  logic        load_iv;
  logic        use_len;

  logic [5:0]  r;
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_w;
  logic [31:0] new_b;

  assign pos       = bit_count[8:3];
  assign cmd_ready = (state == ST_IDLE);
  assign empty     = !out_valid;
  assign rd_addr   = msg_index(cnt[5:0]);
  assign use_len   = !pad_first && (len_phase || pos == LEN_POS);

  // round datapath
  assign r = 6'(cnt - 7'd1);
  always_comb begin
    case (r[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum   = a + f + ROUND_K[r] + rdata;
    rot_w = {sum, sum} << ROUND_S[{r[5:4], r[1:0]}];
    new_b = b + rot_w[63:32];
  end

  // next state and control
  always_comb begin
    state_next     = state;
    ret_next       = ret;
    cnt_next       = cnt;
    bit_count_next = bit_count;
    length_next    = length;
    pad_first_next = pad_first;
    len_phase_next = len_phase;
    out_idx_next   = out_idx;
    out_valid_next = out_valid && !pop;
    wr_en          = 1'b0;
    wr_byte        = cmd.data;
    load_abcd      = 1'b0;
    do_round       = 1'b0;
    do_fin         = 1'b0;
    load_out       = 1'b0;
    load_iv        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_end) begin
            length_next    = cmd.has_byte ? 64'(bit_count + 64'd8) : bit_count;
            pad_first_next = 1'b1;
            len_phase_next = 1'b0;
            state_next     = ST_PAD;
          end
          if (cmd.has_byte) begin
            wr_en          = 1'b1;
            bit_count_next = 64'(bit_count + 64'd8);
            if (pos == LAST_POS) begin
              load_abcd  = 1'b1;
              cnt_next   = 7'd0;
              ret_next   = cmd.is_end ? RET_PAD : RET_IDLE;
              state_next = ST_COMP;
            end
          end
        end
      end
      ST_PAD: begin
        wr_en          = 1'b1;
        wr_byte        = pad_first ? 8'h80 :
                         use_len   ? length[{pos[2:0], 3'b000} +: 8] : 8'h00;
        bit_count_next = 64'(bit_count + 64'd8);
        pad_first_next = 1'b0;
        if (use_len) len_phase_next = 1'b1;
        if (pos == LAST_POS) begin
          load_abcd  = 1'b1;
          cnt_next   = 7'd0;
          ret_next   = use_len ? RET_OUT : RET_PAD;
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        cnt_next = 7'(cnt + 7'd1);
        if (cnt != 7'd0) do_round = 1'b1;
        if (cnt == ROUNDS) state_next = ST_FIN;
      end
      ST_FIN: begin
        do_fin = 1'b1;
        case (ret)
          RET_OUT: begin
            out_idx_next = 2'd0;
            state_next   = ST_OUT;
          end
          RET_PAD: state_next = ST_PAD;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (!out_valid || pop) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          out_idx_next   = 2'(out_idx + 2'd1);
          if (out_idx == 2'd3) begin
            load_iv        = 1'b1;
            bit_count_next = 64'd0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= RET_IDLE;
      cnt       <= 7'd0;
      bit_count <= 64'd0;
      pad_first <= 1'b0;
      len_phase <= 1'b0;
      out_idx   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      cnt       <= cnt_next;
      bit_count <= bit_count_next;
      pad_first <= pad_first_next;
      len_phase <= len_phase_next;
      out_idx   <= out_idx_next;
      out_valid <= out_valid_next;
    end
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (rst || load_iv) begin
      chain[0] <= IV_A;
      chain[1] <= IV_B;
      chain[2] <= IV_C;
      chain[3] <= IV_D;
    end else if (do_fin) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
    end
  end

  // working registers and payload
  always_ff @(posedge clk) begin
    length <= length_next;
    if (load_abcd) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (do_round) begin
      a <= d;
      d <= c;
      c <= b;
      b <= new_b;
    end
    if (load_out) begin
      digest_word <= chain[out_idx];
      word_index  <= out_idx;
      last_word   <= (out_idx == 2'd3);
    end
  end

  // block buffer, byte-lane writes, registered word read
  always_ff @(posedge clk) begin
    if (wr_en) mem[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wr_byte;
    rdata <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> sv/md5_message_digest.sv
// Top level of the MD5 digest block: front queue and back engine.
// Input transactions enter a two-entry queue at one per cycle while it has
// room. The back engine takes one queued byte per cycle while it is idle;
// each completed 64-byte block then runs one word prefetch, 64 rounds of the
// single round unit and one chaining add. An end of message adds 9 to 72
// padding bytes, one or two compressions, and four result words.
// Results are held in an output register and taken with pop.
`default_nettype none
`include "md5_message_digest_defines.svh"
module md5_message_digest import md5_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        end_of_message,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [1:0]       word_index,
  output logic             last_word
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  md5_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_ready      (cmd_ready)
  );

  md5_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready),
    .empty       (empty),
    .pop         (pop),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // assertions
  `MD5_ASSERT(a_last_idx, clk, rst, empty || (last_word == (word_index == 2'd3)))
  `MD5_ASSERT_NEXT(a_burst, clk, rst, !empty && pop && !last_word, !empty)
  `MD5_ASSERT_NEXT(a_idx_step, clk, rst, !empty && pop && !last_word, word_index == 2'($past(word_index) + 2'd1))

endmodule
`default_nettype wire

>>> test/tb_md5_message_digest.sv
// Self-checking testbench for the MD5 message digest block.
`default_nettype none
module tb_md5_message_digest;
  import md5_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_out_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        end_of_message;
  logic        empty;
  logic        pop;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  md5_message_digest dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .data_byte(data_byte), .byte_valid(byte_valid),
    .end_of_message(end_of_message), .empty(empty), .pop(pop),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  // predictor state
  logic [31:0] chain_word [4];
  logic [7:0]  msg_block [64];
  logic [63:0] msg_bits;
  digest_out_t digest_queue [$];

  int  error_count;
  int  idle_cycles;
  int  pop_hold;
  bit  quiet_mode;
  bit  run_done;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // one 64-round compression over msg_block
  function automatic void compress_block();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t, sum;
    int g, ph, sh;
    a = chain_word[0]; b = chain_word[1]; c = chain_word[2]; d = chain_word[3];
    for (int i = 0; i < 16; i++)
      m[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
    for (int r = 0; r < 64; r++) begin
      ph = r / 16;
      case (ph)
        0: begin f = (b & c) | (~b & d); g = r; end
        1: begin f = (b & d) | (c & ~d); g = (1 + 5*r) % 16; end
        2: begin f = b ^ c ^ d; g = (5 + 3*r) % 16; end
        default: begin f = c ^ (b | ~d); g = (7*r) % 16; end
      endcase
      sh = ROUND_S[ph*4 + r%4];
      sum = a + f + ROUND_K[r] + m[g];
      t = d; d = c; c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = t;
    end
    chain_word[0] += a; chain_word[1] += b; chain_word[2] += c; chain_word[3] += d;
  endfunction

  function automatic void absorb(input logic [7:0] v);
    logic [5:0] pos;
    pos = msg_bits[8:3];
    msg_block[pos] = v;
    msg_bits += 64'd8;
    if (pos == LAST_POS) compress_block();
  endfunction

  function automatic void restart_digest();
    chain_word[0] = IV_A; chain_word[1] = IV_B;
    chain_word[2] = IV_C; chain_word[3] = IV_D;
    msg_bits = '0;
  endfunction

  function automatic void predict(input logic [7:0] v, input logic has_byte,
                                  input logic is_end);
    logic [63:0] length;
    digest_out_t e;
    if (has_byte) absorb(v);
    if (!is_end) return;
    length = msg_bits;
    absorb(8'h80);
    while (msg_bits[8:3] != LEN_POS) absorb(8'h00);
    for (int k = 0; k < 8; k++) absorb(length[8*k +: 8]);
    for (int k = 0; k < 4; k++) begin
      e.word = chain_word[k];
      e.index = 2'(k);
      e.last = (k == 3);
      digest_queue.push_back(e);
    end
    restart_digest();
  endfunction

  // send one transaction, with optional idle burst first; push stays high
  // after acceptance so back-to-back transactions need no gap
  task automatic send_item(input logic [7:0] v, input logic has_byte,
                           input logic is_end);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= v;
    byte_valid <= has_byte;
    end_of_message <= is_end;
    do @(posedge clk); while (full);
    predict(v, has_byte, is_end);
  endtask

  // result side: stall bursts, check on each pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (pop && !empty) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("unexpected result", digest_word, 32'h0);
        end else begin
          if (digest_word !== digest_queue[0].word)
            report_mismatch("digest_word", digest_word, digest_queue[0].word);
          if (word_index !== digest_queue[0].index)
            report_mismatch("word_index", 32'(word_index), 32'(digest_queue[0].index));
          if (last_word !== digest_queue[0].last)
            report_mismatch("last_word", 32'(last_word), 32'(digest_queue[0].last));
          void'(digest_queue.pop_front());
        end
      end
      if (quiet_mode) begin
        pop <= 1'b1;
        pop_hold <= 0;
      end else if (pop_hold != 0) begin
        pop <= 1'b0;
        pop_hold <= pop_hold - 1;
      end else if ($urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        pop_hold <= $urandom_range(0, 16);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!run_done && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, (i == len - 1));
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);          // empty message
    send_item(8'hff, 1'b0, 1'b0);          // no byte, no end: ignored
    send_item(8'h61, 1'b1, 1'b1);          // "a"
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);          // end with no byte
  endtask

  // lengths around block and padding boundaries
  task automatic test_boundaries();
    int lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i]);
  endtask

  task automatic test_random();
    int sent;
    int len;
    logic is_end, has_byte;
    sent = 0;
    while (sent < 160) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: gaps and empty ends mixed into a message
        has_byte = $urandom_range(0, 1);
        is_end = ($urandom_range(0, 3) == 0);
        send_item(8'($urandom), has_byte, is_end);
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
        send_message(len);
        sent += (len == 0) ? 1 : len;
      end
      if (sent > 120) quiet_mode = 1'b1;
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    data_byte = '0;
    byte_valid = 1'b0;
    end_of_message = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    quiet_mode = 1'b0;
    run_done = 1'b0;
    restart_digest();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_boundaries();
    test_random();
    push <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    run_done = 1'b1;
    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
